// File: design/dpe_pkg.sv
`default_nettype none

package dpe_pkg;

    // field widths
    localparam int FRAC_BITS = 16;
    localparam int ANGLE_W   = FRAC_BITS + 3;
    localparam int VEL_W     = FRAC_BITS + 5;
    localparam int STEP_W    = 11;
    localparam int DT_W      = 16;

    // internal widths
    localparam int SIN_W     = FRAC_BITS + 1;   // table entry, 0 .. 1.0
    localparam int SV_W      = SIN_W + 1;       // signed sine / cosine
    localparam int ACC_W     = VEL_W + 2;
    localparam int NA_W      = VEL_W + 1;
    localparam int NV_W      = VEL_W + 3;
    localparam int PROD_W    = 48;
    localparam int MUL_A_W   = 34;
    localparam int MUL_B_W   = 27;
    localparam int RQ_W      = PROD_W - FRAC_BITS;
    localparam int PHASE_W   = 12;
    localparam int NUM_W     = 45;
    localparam int REM_W     = 34;
    localparam int PC_W      = 4;

    localparam int MAX_STEPS  = 1024;
    localparam int SINE_DEPTH = 1024;
    localparam int QUAD_BITS  = 10;             // log2 of SINE_DEPTH
    localparam int IDX_W      = QUAD_BITS + 1;

    localparam logic [DT_W-1:0] DT_RESET = 16'd3277;

    // pi in unsigned Q30
    localparam logic [31:0] PI_Q30      = 32'd3373259426;
    localparam logic [31:0] HALF_PI_Q30 = PI_Q30 >> 1;
    localparam logic [REM_W-1:0] REM_LIMIT = REM_W'(3) * REM_W'(PI_Q30);

    // phase = round(|a| * 2^(30-Q) * 2 * DEPTH / pi); the shift folds both factors
    localparam int PHASE_SHIFT = (30 - FRAC_BITS) + QUAD_BITS + 1;
    localparam int RECIP_SHIFT = 32;
    localparam logic [25:0] PHASE_RECIP =
        26'((64'd1 << (PHASE_SHIFT + RECIP_SHIFT)) / 64'(PI_Q30));

    localparam logic [ANGLE_W-1:0] PI_Q =
        ANGLE_W'((64'(PI_Q30) + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
    localparam logic [ANGLE_W:0] TWO_PI_Q =
        (ANGLE_W + 1)'((64'(PI_Q30) * 64'd2 + (64'd1 << (29 - FRAC_BITS)))
                       >> (30 - FRAC_BITS));
    localparam logic [19:0] GRAV = 20'(((64'd98 << FRAC_BITS) + 64'd5) / 64'd10);
    localparam logic [NV_W-1:0] WLIM = NV_W'(8) << FRAC_BITS;

    // sequencer operations, one per control word
    typedef enum logic [3:0] {
        OP_CHECK = 4'd0,
        OP_RECIP = 4'd1,
        OP_EST   = 4'd2,
        OP_REM   = 4'd3,
        OP_CORR  = 4'd4,
        OP_RDS   = 4'd5,
        OP_RDC   = 4'd6,
        OP_GS    = 4'd7,
        OP_ACC1  = 4'd8,
        OP_ACC2  = 4'd9,
        OP_ANG   = 4'd10,
        OP_UPD   = 4'd11,
        OP_EMIT  = 4'd12
    } op_t;

    typedef enum logic [1:0] {
        C_NEXT     = 2'd0,
        C_ALWAYS   = 2'd1,
        C_CNT_ZERO = 2'd2,
        C_REM_GE   = 2'd3
    } cond_t;

    typedef struct packed {
        op_t              op;
        cond_t            cond;
        logic [PC_W-1:0]  target;
    } ucode_t;

    localparam int PROG_LEN = 13;
    localparam logic [PC_W-1:0] PC_CHECK = 4'd0;
    localparam logic [PC_W-1:0] PC_CORR  = 4'd4;
    localparam logic [PC_W-1:0] PC_EMIT  = 4'd12;

    typedef ucode_t ucode_rom_t [0:PROG_LEN-1];

    localparam ucode_rom_t UCODE = '{
        '{op: OP_CHECK, cond: C_CNT_ZERO, target: PC_EMIT},
        '{op: OP_RECIP, cond: C_NEXT,     target: PC_CHECK},
        '{op: OP_EST,   cond: C_NEXT,     target: PC_CHECK},
        '{op: OP_REM,   cond: C_NEXT,     target: PC_CHECK},
        '{op: OP_CORR,  cond: C_REM_GE,   target: PC_CORR},
        '{op: OP_RDS,   cond: C_NEXT,     target: PC_CHECK},
        '{op: OP_RDC,   cond: C_NEXT,     target: PC_CHECK},
        '{op: OP_GS,    cond: C_NEXT,     target: PC_CHECK},
        '{op: OP_ACC1,  cond: C_NEXT,     target: PC_CHECK},
        '{op: OP_ACC2,  cond: C_NEXT,     target: PC_CHECK},
        '{op: OP_ANG,   cond: C_NEXT,     target: PC_CHECK},
        '{op: OP_UPD,   cond: C_ALWAYS,   target: PC_CHECK},
        '{op: OP_EMIT,  cond: C_ALWAYS,   target: PC_CHECK}
    };

    // quarter-wave sine table, taylor series in unsigned q30
    typedef logic [SIN_W-1:0] sine_rom_t [0:SINE_DEPTH];

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t         rom;
        logic [63:0]       x;
        logic [63:0]       x2;
        logic [63:0]       term;
        logic signed [63:0] s;
        logic signed [63:0] e;
        for (int k = 0; k <= SINE_DEPTH; k++)
        begin
            x    = (64'(k) * 64'(PI_Q30) + 64'(SINE_DEPTH)) / 64'(2 * SINE_DEPTH);
            x2   = (x * x + (64'd1 << 29)) >> 30;
            term = x;
            s    = $signed(x);
            for (int n = 1; n <= 9; n++)
            begin
                term = (term * x2 + (64'd1 << 29)) >> 30;
                term = (term + 64'(n * (2 * n + 1))) / 64'((2 * n) * (2 * n + 1));
                if ((n % 2) == 1)
                    s = s - $signed(term);
                else
                    s = s + $signed(term);
            end
            if (s < 0)
                s = 0;
            e = (s + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
            if (e > (64'sd1 <<< FRAC_BITS))
                e = 64'sd1 <<< FRAC_BITS;
            rom[k] = SIN_W'(e);
        end
        return rom;
    endfunction

endpackage

`default_nettype wire

// File: design/damped_pendulum_euler_step.sv
`default_nettype none

// Damped, driven pendulum integrator (forward Euler, Q16 fixed point). Each input item
// carries a start angle, start velocity, torque and step count (capped at 1024); the block
// runs that many Euler steps with g = 9.8 and unit length, mass and damping, wrapping the
// angle once into [-pi, pi] and clamping the velocity to [-8, 8] after every step, and
// returns the final angle and velocity as one result item. Sine and cosine come from a
// nearest-entry quarter-wave table of 1025 entries held in a registered ROM. The time step
// is set through cfg_wr_en / cfg_wr_data (unsigned Q0.16, reset 3277) and must only be
// written while the block is idle. One item is worked at a time: each step runs the
// microcode sequence once, with one extra correction pass for each phase correction (zero
// to two per step). The sequence is shaped around the single shared multiplier and the
// single ROM read port. The result sits in an output register, so a new item can be taken
// while the previous result waits for out_ready.
module damped_pendulum_euler_step (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // configuration
    input  wire logic                               cfg_wr_en,
    input  wire logic [dpe_pkg::DT_W-1:0]           cfg_wr_data,
    // input items
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic signed [dpe_pkg::ANGLE_W-1:0] start_angle,
    input  wire logic signed [dpe_pkg::VEL_W-1:0]   start_velocity,
    input  wire logic signed [dpe_pkg::VEL_W-1:0]   torque,
    input  wire logic [dpe_pkg::STEP_W-1:0]         step_count,
    // result items
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic signed [dpe_pkg::ANGLE_W-1:0]      end_angle,
    output logic signed [dpe_pkg::VEL_W-1:0]        end_velocity
);

    localparam dpe_pkg::sine_rom_t SINE_ROM = dpe_pkg::build_sine_rom();

    // table index for a phase: quadrant picks mirroring
    function automatic logic [dpe_pkg::IDX_W-1:0] rom_index(
        input logic [dpe_pkg::PHASE_W-1:0] ph
    );
        logic [dpe_pkg::IDX_W-1:0] r;
        r = dpe_pkg::IDX_W'(ph[dpe_pkg::QUAD_BITS-1:0]);
        if (ph[dpe_pkg::QUAD_BITS])
            return dpe_pkg::IDX_W'(dpe_pkg::SINE_DEPTH) - r;
        else
            return r;
    endfunction

    function automatic logic signed [dpe_pkg::SV_W-1:0] apply_sign(
        input logic [dpe_pkg::SIN_W-1:0] v,
        input logic                      neg
    );
        logic signed [dpe_pkg::SV_W-1:0] m;
        m = $signed({1'b0, v});
        return neg ? -m : m;
    endfunction

    // ---------------- control state ----------------
    logic                          busy_reg,      busy_next;
    logic [dpe_pkg::PC_W-1:0]      pc_reg,        pc_next;
    logic [dpe_pkg::STEP_W-1:0]    cnt_reg,       cnt_next;
    logic                          out_valid_reg, out_valid_next;
    logic [dpe_pkg::DT_W-1:0]      time_step_reg, time_step_next;

    // ---------------- datapath ----------------
    logic signed [dpe_pkg::ANGLE_W-1:0] ang_reg,  ang_next;
    logic signed [dpe_pkg::VEL_W-1:0]   vel_reg,  vel_next;
    logic signed [dpe_pkg::VEL_W-1:0]   tq_reg,   tq_next;
    logic signed [dpe_pkg::PROD_W-1:0]  prod_reg, prod_next;
    logic [dpe_pkg::PHASE_W-1:0]        p_reg,    p_next;
    logic [dpe_pkg::REM_W-1:0]          rem_reg,  rem_next;
    logic signed [dpe_pkg::SV_W-1:0]    sin_reg,  sin_next;
    logic signed [dpe_pkg::SV_W-1:0]    cos_reg,  cos_next;
    logic signed [dpe_pkg::ACC_W-1:0]   acc_reg,  acc_next;
    logic signed [dpe_pkg::NA_W-1:0]    na_reg,   na_next;
    logic [dpe_pkg::SIN_W-1:0]          rom_reg;
    logic signed [dpe_pkg::ANGLE_W-1:0] end_angle_reg,    end_angle_next;
    logic signed [dpe_pkg::VEL_W-1:0]   end_velocity_reg, end_velocity_next;

    dpe_pkg::ucode_t                    uc;
    logic                               in_fire;
    logic                               stall;
    logic                               taken;
    logic                               rem_ge;
    logic [dpe_pkg::ANGLE_W-1:0]        mag;
    logic [dpe_pkg::NUM_W-1:0]          num;
    logic [dpe_pkg::NUM_W-1:0]          rem_diff;
    logic [dpe_pkg::PHASE_W-1:0]        est;
    logic [dpe_pkg::PHASE_W-1:0]        cos_ph;
    logic [dpe_pkg::IDX_W-1:0]          rom_addr;
    logic signed [dpe_pkg::MUL_A_W-1:0] mul_a;
    logic signed [dpe_pkg::MUL_B_W-1:0] mul_b;
    logic signed [dpe_pkg::MUL_A_W+dpe_pkg::MUL_B_W-1:0] mul_p;
    logic signed [dpe_pkg::PROD_W-1:0]  rnd;
    logic signed [dpe_pkg::RQ_W-1:0]    rq;         // rounded Q product of prod_reg
    logic signed [dpe_pkg::NA_W-1:0]    wrapped;
    logic signed [dpe_pkg::NV_W-1:0]    nv;

    assign uc       = dpe_pkg::UCODE[pc_reg];
    assign in_ready = !busy_reg;
    assign in_fire  = in_valid && in_ready;
    assign stall    = (uc.op == dpe_pkg::OP_EMIT) && out_valid_reg && !out_ready;

    assign out_valid    = out_valid_reg;
    assign end_angle    = end_angle_reg;
    assign end_velocity = end_velocity_reg;

    // phase of |angle|: estimate by reciprocal, then correct by compare/subtract
    assign mag      = ang_reg[dpe_pkg::ANGLE_W-1] ? (~ang_reg + 1'b1) : ang_reg;
    assign num      = (dpe_pkg::NUM_W'(mag) << dpe_pkg::PHASE_SHIFT)
                      + dpe_pkg::NUM_W'(dpe_pkg::HALF_PI_Q30);
    assign est      = prod_reg[dpe_pkg::RECIP_SHIFT+dpe_pkg::PHASE_W-1:dpe_pkg::RECIP_SHIFT];
    assign rem_diff = num - prod_reg[dpe_pkg::NUM_W-1:0];
    assign rem_ge   = rem_reg >= dpe_pkg::REM_W'(dpe_pkg::PI_Q30);
    assign cos_ph   = p_reg + dpe_pkg::PHASE_W'(dpe_pkg::SINE_DEPTH);
    assign rom_addr = (uc.op == dpe_pkg::OP_RDC) ? rom_index(cos_ph) : rom_index(p_reg);

    // round half up, floor shift
    assign rnd = prod_reg + (dpe_pkg::PROD_W'(1) <<< (dpe_pkg::FRAC_BITS - 1));
    assign rq  = $signed(rnd[dpe_pkg::PROD_W-1:dpe_pkg::FRAC_BITS]);

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (uc.op)
            dpe_pkg::OP_RECIP:
            begin
                mul_a = $signed(dpe_pkg::MUL_A_W'(mag));
                mul_b = $signed({1'b0, dpe_pkg::PHASE_RECIP});
            end
            dpe_pkg::OP_EST:
            begin
                mul_a = $signed(dpe_pkg::MUL_A_W'(dpe_pkg::PI_Q30));
                mul_b = $signed(dpe_pkg::MUL_B_W'(est));
            end
            dpe_pkg::OP_GS:
            begin
                mul_a = dpe_pkg::MUL_A_W'(sin_reg);
                mul_b = $signed(dpe_pkg::MUL_B_W'(dpe_pkg::GRAV));
            end
            dpe_pkg::OP_ACC1:
            begin
                mul_a = dpe_pkg::MUL_A_W'(cos_reg);
                mul_b = dpe_pkg::MUL_B_W'(tq_reg);
            end
            dpe_pkg::OP_ACC2:
            begin
                mul_a = dpe_pkg::MUL_A_W'(vel_reg);
                mul_b = $signed(dpe_pkg::MUL_B_W'(time_step_reg));
            end
            dpe_pkg::OP_ANG:
            begin
                mul_a = dpe_pkg::MUL_A_W'(acc_reg);
                mul_b = $signed(dpe_pkg::MUL_B_W'(time_step_reg));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // angle wrap once into [-pi, pi]; the update step then saturates to the field range
    always_comb
    begin
        if (na_reg < -$signed(dpe_pkg::NA_W'(dpe_pkg::PI_Q)))
            wrapped = na_reg + $signed(dpe_pkg::NA_W'(dpe_pkg::TWO_PI_Q));
        else if (na_reg > $signed(dpe_pkg::NA_W'(dpe_pkg::PI_Q)))
            wrapped = na_reg - $signed(dpe_pkg::NA_W'(dpe_pkg::TWO_PI_Q));
        else
            wrapped = na_reg;
    end

    assign nv = dpe_pkg::NV_W'(vel_reg) + $signed(rq[dpe_pkg::NV_W-1:0]);

    // branch condition
    always_comb
    begin
        case (uc.cond)
            dpe_pkg::C_NEXT:     taken = 1'b0;
            dpe_pkg::C_ALWAYS:   taken = 1'b1;
            dpe_pkg::C_CNT_ZERO: taken = (cnt_reg == '0);
            dpe_pkg::C_REM_GE:   taken = rem_ge;
            default:             taken = 1'b0;
        endcase
    end

    // next state
    always_comb
    begin
        busy_next         = busy_reg;
        pc_next           = pc_reg;
        cnt_next          = cnt_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        time_step_next    = cfg_wr_en ? cfg_wr_data : time_step_reg;
        ang_next          = ang_reg;
        vel_next          = vel_reg;
        tq_next           = tq_reg;
        prod_next         = prod_reg;
        p_next            = p_reg;
        rem_next          = rem_reg;
        sin_next          = sin_reg;
        cos_next          = cos_reg;
        acc_next          = acc_reg;
        na_next           = na_reg;
        end_angle_next    = end_angle_reg;
        end_velocity_next = end_velocity_reg;

        if (!busy_reg)
        begin
            // idle: sequencer parked on the count check
            if (in_fire)
            begin
                busy_next = 1'b1;
                ang_next  = start_angle;
                vel_next  = start_velocity;
                tq_next   = torque;
                cnt_next  = (step_count > dpe_pkg::STEP_W'(dpe_pkg::MAX_STEPS))
                            ? dpe_pkg::STEP_W'(dpe_pkg::MAX_STEPS) : step_count;
            end
        end
        else
        begin
            if (stall)
                pc_next = pc_reg;
            else if (taken)
                pc_next = uc.target;
            else
                pc_next = pc_reg + 1'b1;

            case (uc.op)
                dpe_pkg::OP_CHECK:
                begin
                    cnt_next = cnt_reg;
                end
                dpe_pkg::OP_RECIP:
                begin
                    prod_next = mul_p[dpe_pkg::PROD_W-1:0];
                end
                dpe_pkg::OP_EST:
                begin
                    p_next    = est;
                    prod_next = mul_p[dpe_pkg::PROD_W-1:0];
                end
                dpe_pkg::OP_REM:
                begin
                    rem_next = rem_diff[dpe_pkg::REM_W-1:0];
                end
                dpe_pkg::OP_CORR:
                begin
                    if (rem_ge)
                    begin
                        rem_next = rem_reg - dpe_pkg::REM_W'(dpe_pkg::PI_Q30);
                        p_next   = p_reg + 1'b1;
                    end
                end
                dpe_pkg::OP_RDS:
                begin
                    // sine entry is being fetched
                    p_next = p_reg;
                end
                dpe_pkg::OP_RDC:
                begin
                    // sine takes the sign of the angle on top of its quadrant
                    sin_next = apply_sign(rom_reg,
                        p_reg[dpe_pkg::QUAD_BITS+1] ^ ang_reg[dpe_pkg::ANGLE_W-1]);
                end
                dpe_pkg::OP_GS:
                begin
                    cos_next  = apply_sign(rom_reg, cos_ph[dpe_pkg::QUAD_BITS+1]);
                    prod_next = mul_p[dpe_pkg::PROD_W-1:0];
                end
                dpe_pkg::OP_ACC1:
                begin
                    // -g*sin - vel
                    acc_next  = -$signed(rq[dpe_pkg::ACC_W-1:0]) - dpe_pkg::ACC_W'(vel_reg);
                    prod_next = mul_p[dpe_pkg::PROD_W-1:0];
                end
                dpe_pkg::OP_ACC2:
                begin
                    // + cos*torque
                    acc_next  = acc_reg + $signed(rq[dpe_pkg::ACC_W-1:0]);
                    prod_next = mul_p[dpe_pkg::PROD_W-1:0];
                end
                dpe_pkg::OP_ANG:
                begin
                    na_next   = dpe_pkg::NA_W'(ang_reg) + $signed(rq[dpe_pkg::NA_W-1:0]);
                    prod_next = mul_p[dpe_pkg::PROD_W-1:0];
                end
                dpe_pkg::OP_UPD:
                begin
                    if (wrapped > $signed(dpe_pkg::NA_W'({1'b0, {(dpe_pkg::ANGLE_W-1){1'b1}}})))
                        ang_next = $signed({1'b0, {(dpe_pkg::ANGLE_W-1){1'b1}}});
                    else if (wrapped < -$signed(dpe_pkg::NA_W'(1) <<< (dpe_pkg::ANGLE_W-1)))
                        ang_next = $signed({1'b1, {(dpe_pkg::ANGLE_W-1){1'b0}}});
                    else
                        ang_next = $signed(wrapped[dpe_pkg::ANGLE_W-1:0]);

                    if (nv < -$signed(dpe_pkg::WLIM))
                        vel_next = -$signed(dpe_pkg::VEL_W'(dpe_pkg::WLIM));
                    else if (nv > $signed(dpe_pkg::WLIM))
                        vel_next = $signed(dpe_pkg::VEL_W'(dpe_pkg::WLIM));
                    else
                        vel_next = $signed(nv[dpe_pkg::VEL_W-1:0]);

                    cnt_next = cnt_reg - 1'b1;
                end
                dpe_pkg::OP_EMIT:
                begin
                    if (!stall)
                    begin
                        out_valid_next    = 1'b1;
                        end_angle_next    = ang_reg;
                        end_velocity_next = vel_reg;
                        busy_next         = 1'b0;
                    end
                end
                default:
                begin
                    busy_next = busy_reg;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pc_reg        <= dpe_pkg::PC_CHECK;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            time_step_reg <= dpe_pkg::DT_RESET;
        end
        else
        begin
            busy_reg      <= busy_next;
            pc_reg        <= pc_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            time_step_reg <= time_step_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        ang_reg          <= ang_next;
        vel_reg          <= vel_next;
        tq_reg           <= tq_next;
        prod_reg         <= prod_next;
        p_reg            <= p_next;
        rem_reg          <= rem_next;
        sin_reg          <= sin_next;
        cos_reg          <= cos_next;
        acc_reg          <= acc_next;
        na_reg           <= na_next;
        end_angle_reg    <= end_angle_next;
        end_velocity_reg <= end_velocity_next;
    end

    // sine rom, registered read
    always_ff @(posedge clk)
    begin
        rom_reg <= SINE_ROM[rom_addr];
    end

    // ---------------- assertions ----------------

    // phase remainder never needs more than two corrections
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && pc_reg == dpe_pkg::PC_CORR) |-> (rem_reg < dpe_pkg::REM_LIMIT))
        else $error("phase remainder out of range");

    // sequencer parks on the count check while idle
    a_idle_pc: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (pc_reg == dpe_pkg::PC_CHECK))
        else $error("sequencer moved while idle");

    // finishing an item always leaves a result in the output register
    a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> out_valid_reg)
        else $error("item finished without result");

    // step counter never exceeds the cap
    a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= dpe_pkg::STEP_W'(dpe_pkg::MAX_STEPS))
        else $error("step counter above cap");

endmodule

`default_nettype wire

// File: sim/testbench.sv
`default_nettype none

module testbench;

    localparam int AW    = dpe_pkg::ANGLE_W;
    localparam int VW    = dpe_pkg::VEL_W;
    localparam int SW    = dpe_pkg::STEP_W;
    localparam int DW    = dpe_pkg::DT_W;
    localparam int FRAC  = dpe_pkg::FRAC_BITS;
    localparam int DEPTH = dpe_pkg::SINE_DEPTH;
    localparam int STEP_CAP = dpe_pkg::MAX_STEPS;

    // fixed-point constants of the pendulum, worked out from pi in q30
    localparam longint unsigned PI_Q30 = 64'(dpe_pkg::PI_Q30);
    localparam longint PI_FIX  = longint'((PI_Q30 + (64'd1 << (29 - FRAC))) >> (30 - FRAC));
    localparam longint TWO_PI_FIX =
        longint'((64'd2 * PI_Q30 + (64'd1 << (29 - FRAC))) >> (30 - FRAC));
    localparam longint GRAV_FIX = ((longint'(98) <<< FRAC) + 5) / 10;
    localparam longint VEL_LIM  = longint'(8) <<< FRAC;
    localparam longint ANG_MAX  = (longint'(1) <<< (AW - 1)) - 1;
    localparam longint ANG_MIN  = -ANG_MAX - 1;
    localparam longint VEL_MAX  = (longint'(1) <<< (VW - 1)) - 1;
    localparam longint VEL_MIN  = -VEL_MAX - 1;

    localparam logic [DW-1:0] DT_AT_RESET = dpe_pkg::DT_RESET;

    // timeout for the whole run, stalls included
    localparam longint CYCLE_LIMIT = 10_000_000;
    // quiet time after the last result: one full item at the longest step count
    localparam int TAIL_CYCLES = 15000;
    localparam int MAX_LONG_RUNS = 24;

    typedef struct {
        logic signed [AW-1:0] angle;
        logic signed [VW-1:0] velocity;
        logic signed [VW-1:0] torque;
        logic [SW-1:0]        steps;
    } swing_start_t;

    typedef struct {
        logic signed [AW-1:0] angle;
        logic signed [VW-1:0] velocity;
    } swing_end_t;

    // holds the predicted final states of accepted items, oldest first
    class pendulum_scoreboard;
        longint          sine_q [0:DEPTH];
        longint unsigned time_step;
        swing_end_t      pending_ends [$];
        int              mismatches;

        function new();
            time_step  = longint'(DT_AT_RESET);
            mismatches = 0;
            build_sine_table();
        endfunction

        // quarter-wave sine, 10-term taylor series in unsigned q30
        function void build_sine_table();
            longint unsigned x;
            longint unsigned x2;
            longint unsigned term;
            longint          s;
            longint          e;
            int              k;
            int              n;
            for (k = 0; k <= DEPTH; k++)
            begin
                x    = (64'(k) * PI_Q30 + 64'(DEPTH)) / 64'(2 * DEPTH);
                x2   = (x * x + (64'd1 << 29)) >> 30;
                term = x;
                s    = longint'(x);
                for (n = 1; n <= 9; n++)
                begin
                    term = (term * x2 + (64'd1 << 29)) >> 30;
                    term = (term + 64'(n * (2 * n + 1))) / 64'((2 * n) * (2 * n + 1));
                    if ((n % 2) == 1)
                        s = s - longint'(term);
                    else
                        s = s + longint'(term);
                end
                if (s < 0)
                    s = 0;
                e = (s + (longint'(1) <<< (29 - FRAC))) >>> (30 - FRAC);
                if (e > (longint'(1) <<< FRAC))
                    e = longint'(1) <<< FRAC;
                sine_q[k] = e;
            end
        endfunction

        function longint fix_mul(longint a, longint b);
            return (a * b + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
        endfunction

        // mirror and negate the quarter table by quadrant
        function longint wave_at(longint unsigned phase);
            longint unsigned quad;
            longint unsigned r;
            longint unsigned idx;
            longint          v;
            quad = (phase / DEPTH) % 4;
            r    = phase % DEPTH;
            idx  = ((quad & 1) != 0) ? DEPTH - r : r;
            v    = sine_q[idx];
            return ((quad & 2) != 0) ? -v : v;
        endfunction

        function void sin_cos(longint a, output longint s, output longint c);
            longint unsigned mag;
            longint unsigned phase;
            longint          sv;
            mag   = (a < 0) ? longint'(-a) : longint'(a);
            phase = ((mag << (30 - FRAC)) * 64'(2 * DEPTH) + PI_Q30 / 2) / PI_Q30;
            sv    = wave_at(phase);
            s     = (a < 0) ? -sv : sv;
            c     = wave_at(phase + DEPTH);
        endfunction

        // forward euler over the item's step count at the current time step
        function swing_end_t integrate(swing_start_t item);
            swing_end_t res;
            longint     ang;
            longint     vel;
            longint     tq;
            longint     dt;
            longint     s;
            longint     c;
            longint     acc;
            longint     na;
            longint     nv;
            int         n_steps;
            ang     = item.angle;
            vel     = item.velocity;
            tq      = item.torque;
            dt      = longint'(time_step);
            n_steps = (int'(item.steps) > STEP_CAP) ? STEP_CAP : int'(item.steps);
            for (int i = 0; i < n_steps; i++)
            begin
                sin_cos(ang, s, c);
                acc = -fix_mul(GRAV_FIX, s) - vel + fix_mul(c, tq);
                na  = ang + fix_mul(dt, vel);
                nv  = vel + fix_mul(dt, acc);
                // single wrap, then saturate to the angle field
                if (na < -PI_FIX)
                    na = na + TWO_PI_FIX;
                else if (na > PI_FIX)
                    na = na - TWO_PI_FIX;
                if (na > ANG_MAX)
                    na = ANG_MAX;
                else if (na < ANG_MIN)
                    na = ANG_MIN;
                if (nv < -VEL_LIM)
                    nv = -VEL_LIM;
                else if (nv > VEL_LIM)
                    nv = VEL_LIM;
                ang = na;
                vel = nv;
            end
            res.angle    = ang[AW-1:0];
            res.velocity = vel[VW-1:0];
            return res;
        endfunction

        function void note_start(swing_start_t item);
            pending_ends.push_back(integrate(item));
        endfunction

        function void check_end(logic signed [AW-1:0] angle, logic signed [VW-1:0] velocity);
            swing_end_t want;
            if (pending_ends.size() == 0)
            begin
                $display("%0t: result with none expected, angle %0d velocity %0d",
                         $time, angle, velocity);
                mismatches++;
                return;
            end
            want = pending_ends.pop_front();
            if (angle !== want.angle)
            begin
                $display("%0t: end_angle expected %0d actual %0d", $time, want.angle, angle);
                mismatches++;
            end
            if (velocity !== want.velocity)
            begin
                $display("%0t: end_velocity expected %0d actual %0d",
                         $time, want.velocity, velocity);
                mismatches++;
            end
        endfunction

        function int pending();
            return pending_ends.size();
        endfunction
    endclass

    // dut interface, every input known from time zero
    logic                 clk            = 1'b0;
    logic                 rst_n          = 1'b0;
    logic                 cfg_wr_en      = 1'b0;
    logic [DW-1:0]        cfg_wr_data    = '0;
    logic                 in_valid       = 1'b0;
    logic                 in_ready;
    logic signed [AW-1:0] start_angle    = '0;
    logic signed [VW-1:0] start_velocity = '0;
    logic signed [VW-1:0] torque         = '0;
    logic [SW-1:0]        step_count     = '0;
    logic                 out_valid;
    logic                 out_ready      = 1'b0;
    logic signed [AW-1:0] end_angle;
    logic signed [VW-1:0] end_velocity;

    pendulum_scoreboard swing_board = new();

    // both sides skip their random gaps while this is set
    bit     steady     = 1'b0;
    int     long_runs  = 0;
    longint cycle_count = 0;

    damped_pendulum_euler_step uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .start_angle    (start_angle),
        .start_velocity (start_velocity),
        .torque         (torque),
        .step_count     (step_count),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .end_angle      (end_angle),
        .end_velocity   (end_velocity)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // hang guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // returns at a falling edge once every predicted result has been taken
    task automatic wait_drained();
        while (swing_board.pending() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // one item: optional gap or full drain first, then hold valid until taken
    task automatic send_start(input swing_start_t item);
        int gap;
        bit drain;
        gap   = steady ? 0 : $urandom_range(0, 16);
        drain = ($urandom_range(0, 49) == 0);
        @(negedge clk);
        if (gap > 0 || drain)
        begin
            in_valid = 1'b0;
            if (drain)
                wait_drained();
            repeat (gap) @(negedge clk);
        end
        start_angle    = item.angle;
        start_velocity = item.velocity;
        torque         = item.torque;
        step_count     = item.steps;
        in_valid       = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        swing_board.note_start(item);
    endtask

    task automatic send_fields(input longint a, input longint v, input longint t,
                               input int n);
        swing_start_t item;
        item.angle    = a[AW-1:0];
        item.velocity = v[VW-1:0];
        item.torque   = t[VW-1:0];
        item.steps    = n[SW-1:0];
        send_start(item);
    endtask

    // time step may only change with the block idle
    task automatic set_time_step(input logic [DW-1:0] dt);
        @(negedge clk);
        in_valid = 1'b0;
        wait_drained();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = dt;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        swing_board.time_step = longint'(dt);
    endtask

    // mostly in-range starts with short runs, some full-width noise and a few long runs
    function automatic swing_start_t random_start();
        swing_start_t item;
        logic [31:0]  r;
        int           pick;
        r    = $urandom;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            item.angle = r[AW-1:0];
        else if (pick == 1)
            case ($urandom_range(0, 3))
                0: item.angle = PI_FIX[AW-1:0];
                1: item.angle = AW'(-PI_FIX);
                2: item.angle = ANG_MAX[AW-1:0];
                default: item.angle = ANG_MIN[AW-1:0];
            endcase
        else
            item.angle = AW'(longint'($urandom_range(0, 32'(2 * PI_FIX))) - PI_FIX);
        r = $urandom;
        if ($urandom_range(0, 7) == 0)
            item.velocity = r[VW-1:0];
        else
            item.velocity = VW'(longint'($urandom_range(0, 32'(2 * VEL_LIM))) - VEL_LIM);
        r = $urandom;
        if ($urandom_range(0, 7) == 0)
            item.torque = r[VW-1:0];
        else
            item.torque = VW'(longint'($urandom_range(0, 32'(2 * VEL_LIM))) - VEL_LIM);
        pick = $urandom_range(0, 99);
        if (pick < 2 && long_runs < MAX_LONG_RUNS)
        begin
            long_runs++;
            item.steps = SW'($urandom_range(STEP_CAP, (1 << SW) - 1));
        end
        else if (pick < 10)
            item.steps = SW'($urandom_range(25, 200));
        else
            item.steps = SW'($urandom_range(0, 24));
        return item;
    endfunction

    task automatic run_phase(input logic [DW-1:0] dt, input int count);
        set_time_step(dt);
        repeat (count)
        begin
            if ($urandom_range(0, 31) == 0)
                steady = !steady;
            send_start(random_start());
        end
    endtask

    // result side: random stall before each result, then take it
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 16);
            repeat (stall)
            begin
                @(negedge clk);
                out_ready = 1'b0;
            end
            @(negedge clk);
            out_ready = 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            swing_board.check_end(end_angle, end_velocity);
        end
    end

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // time step left at its reset value
        send_fields(0, 0, 0, 0);                        // zero steps
        send_fields(ANG_MAX, VEL_MAX, VEL_MIN, 0);      // widest fields pass through
        send_fields(ANG_MIN, VEL_MIN, VEL_MAX, 0);
        send_fields(PI_FIX, 0, 0, 1);
        send_fields(-PI_FIX, 0, 0, 1);
        send_fields(ANG_MAX, 0, 0, 1);                  // angle far out, wrapped once
        send_fields(ANG_MIN, VEL_MIN, 0, 3);
        send_fields(0, VEL_LIM, VEL_LIM, 10);
        send_fields(0, -VEL_LIM, -VEL_LIM, 10);
        send_fields(PI_FIX / 2, 0, VEL_MAX, 5);         // torque beyond the velocity limit
        send_fields(-PI_FIX / 2, 0, VEL_MIN, 5);
        send_fields(1000, VEL_MAX, 0, 1);               // velocity clamp
        send_fields(PI_FIX / 2, 0, 0, 50);
        send_fields(-100000, 300000, 200000, 7);
        send_fields(PI_FIX, VEL_LIM, 0, STEP_CAP);
        send_fields(-50000, -VEL_LIM, VEL_LIM, STEP_CAP + 1);   // count saturates
        send_fields(123456, 0, -200000, (1 << SW) - 1);

        // zero time step: nothing moves, but wrap and clamp still act
        set_time_step('0);
        send_fields(ANG_MAX, 0, 0, 2);
        send_fields(ANG_MIN, VEL_MAX, 0, 1);
        send_fields(PI_FIX, VEL_MIN, VEL_LIM, 3);
        send_fields(0, 0, 0, 0);
        repeat (30)
            send_start(random_start());

        run_phase('1, 110);
        run_phase(16'd1, 110);
        repeat (4)
            run_phase(16'($urandom_range(1, (1 << DW) - 1)), 110);
        run_phase(DT_AT_RESET, 60);

        @(negedge clk);
        in_valid = 1'b0;
        wait_drained();
        // catch any stray result after the last expected one
        repeat (TAIL_CYCLES) @(posedge clk);

        if (swing_board.mismatches == 0 && swing_board.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

// File: damped_pendulum_euler_step.f
design/dpe_pkg.sv
design/damped_pendulum_euler_step.sv
sim/testbench.sv
